### rtl/cansm_pkg.sv
// Package for the CAN signal unpack mapper.
// Holds the table sizes, request/response/command types and code constants.
// No dependencies.
`default_nettype none

package cansm_pkg;

   localparam int MAX_IDS   = 10;
   localparam int MAX_MAPS  = 8;
   localparam int FRAC_BITS = 5;
   localparam int Q_DEPTH   = 2;

   localparam int CNT_W     = $clog2(MAX_IDS + 1);
   localparam int IX_W      = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
   localparam int MC_W      = $clog2(MAX_MAPS + 1);
   localparam int MAP_DEPTH = MAX_IDS * MAX_MAPS;
   localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int QP_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int QC_W      = $clog2(Q_DEPTH + 1);
   localparam int PROD_W    = 40;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_FRAME = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_NOMATCH = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_ID     = 3'd1;
   localparam logic [2:0] ST_BAD_OFFSET = 3'd2;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
   localparam logic [2:0] ST_ID_FULL    = 3'd4;
   localparam logic [2:0] ST_LIST_FULL  = 3'd5;

   localparam logic [5:0] MAX_LENGTH = 6'd32;

   typedef struct packed {
      logic [1:0]         func;
      logic [10:0]        can_id;
      logic [63:0]        frame_data;
      logic [7:0]         param_index;
      logic [5:0]         bit_offset;
      logic [5:0]         bit_length;
      logic signed [7:0]  gain;
      logic               offset_too_big;
      logic               length_too_big;
      logic               id_too_big;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         status;
      logic [3:0]         id_count;
      logic [7:0]         write_index;
      logic signed [31:0] write_value;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_FRAME,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [2:0]         status;
      logic [10:0]        can_id;
      logic [63:0]        frame_data;
      logic [7:0]         param_index;
      logic [5:0]         bit_offset;
      logic [5:0]         bit_length;
      logic signed [7:0]  gain;
   } cmd_type;

   typedef struct packed {
      logic [7:0]         param;
      logic signed [7:0]  gain;
      logic [5:0]         offset;
      logic [5:0]         length;
   } map_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_READ,
      S_MUL,
      S_EMIT,
      S_RESP
   } back_state_type;

endpackage

`default_nettype wire

### rtl/can_signal_unpack_mapper.sv
// Top level of the CAN signal unpack mapper.
// Depends on cansm_pkg, cansm_front, cansm_queue and cansm_back.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+--------------------------------
//   request  | req_valid, req_ready, req_data | add, frame or clear (req_type)
//   response | rsp_valid, rsp_ready, rsp_data | status, write or no-match
//
// Add: one rejected by the front-end checks goes straight to the response, else
// after an identifier search (one entry per cycle).
// Frame: identifier search, then each mapping passes through the mapping memory
// read, the multiply register and the response register. Clear: straight to
// the response. A two-deep queue takes requests while the back end works.
// Reset clears control state and the identifier count; no clearing pass.
`default_nettype none

module can_signal_unpack_mapper import cansm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    q_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    q_valid;
   cmd_type head;

   cansm_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   cansm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .head     (head)
   );

   cansm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/cansm_front.sv
// Front end: accepts requests, checks add arguments and classifies them.
// Depends on cansm_pkg; feeds cansm_queue.
`default_nettype none

module cansm_front import cansm_pkg::*; (
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    q_full,
   output logic         push,
   output cmd_type      push_cmd
);

   logic    known;
   op_type  op;
   logic [2:0] status;

   always_comb begin
      known = 1'b1;
      op    = OP_ADD;
      case (req_data.func)
         FUNC_ADD:   op = OP_ADD;
         FUNC_FRAME: op = OP_FRAME;
         FUNC_CLEAR: op = OP_CLEAR;
         default:    known = 1'b0;
      endcase

      if (req_data.id_too_big) begin
         status = ST_BAD_ID;
      end else if (req_data.offset_too_big) begin
         status = ST_BAD_OFFSET;
      end else if (req_data.length_too_big || (req_data.bit_length > MAX_LENGTH)) begin
         status = ST_BAD_LENGTH;
      end else begin
         status = ST_OK;
      end
   end

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full && known;

   always_comb begin
      push_cmd.op          = op;
      push_cmd.status      = (op == OP_ADD) ? status : ST_OK;
      push_cmd.can_id      = req_data.can_id;
      push_cmd.frame_data  = req_data.frame_data;
      push_cmd.param_index = req_data.param_index;
      push_cmd.bit_offset  = req_data.bit_offset;
      push_cmd.bit_length  = req_data.bit_length;
      push_cmd.gain        = req_data.gain;
   end

endmodule

`default_nettype wire

### rtl/cansm_queue.sv
// Short command queue between front end and back end.
// Depends on cansm_pkg.
`default_nettype none

module cansm_queue import cansm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         q_valid,
   output cmd_type      head
);

   cmd_type           slot_ff [Q_DEPTH];
   logic [QP_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == QC_W'(Q_DEPTH));
   assign q_valid = (count_ff != '0);
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/cansm_back.sv
// Back end: identifier table, mapping memory, field scaling and response register.
// Depends on cansm_pkg; takes commands from cansm_queue.
`default_nettype none

module cansm_back import cansm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    id_count_ff, id_count_in;
   logic [MC_W-1:0]     j_ff, j_in;
   logic [MC_W-1:0]     n_ff, n_in;
   rsp_type             pend_ff, pend_in;

   logic [10:0]         id_store [MAX_IDS];
   logic [MC_W-1:0]     map_count [MAX_IDS];
   map_type             map_mem [MAP_DEPTH];
   map_type             map_rd_ff;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [7:0]               param_ff;

   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic [IX_W-1:0]     ix;
   logic                miss, hit;
   logic [MC_W-1:0]     mc_cur, mc_sel;
   logic [MAP_AW-1:0]   base;
   logic                id_we, mc_we, map_we;
   logic [MC_W-1:0]     mc_wdata;
   logic [MAP_AW-1:0]   map_waddr, map_raddr;
   map_type             map_wdata;
   logic                out_free, rsp_load;
   rsp_type             rsp_load_data;

   logic [31:0]         word, mask;
   logic signed [31:0]  field;

   assign ix     = idx_ff[IX_W-1:0];
   assign miss   = (idx_ff == id_count_ff);
   assign hit    = !miss && (id_store[ix] == cmd_ff.can_id);
   assign mc_cur = map_count[ix];
   assign mc_sel = miss ? '0 : mc_cur;
   assign base   = MAP_AW'(idx_ff) * MAP_AW'(MAX_MAPS);

   assign map_waddr = base + MAP_AW'(mc_sel);
   assign map_raddr = base + MAP_AW'(j_ff);

   always_comb begin
      map_wdata.param  = cmd_ff.param_index;
      map_wdata.gain   = cmd_ff.gain;
      map_wdata.offset = cmd_ff.bit_offset;
      map_wdata.length = cmd_ff.bit_length;
   end

   always_comb begin
      word    = map_rd_ff.offset[5] ? cmd_ff.frame_data[63:32] : cmd_ff.frame_data[31:0];
      mask    = ~({32{1'b1}} << map_rd_ff.length);
      field   = (word >> map_rd_ff.offset[4:0]) & mask;
      prod_in = PROD_W'(field) * PROD_W'(map_rd_ff.gain);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      id_count_in   = id_count_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pop           = 1'b0;
      id_we         = 1'b0;
      mc_we         = 1'b0;
      mc_wdata      = '0;
      map_we        = 1'b0;
      rsp_load      = 1'b0;
      rsp_load_data = pend_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               idx_in = '0;
               j_in   = '0;
               pend_in = '0;
               pend_in.kind = KIND_STATUS;
               pend_in.last = 1'b1;
               case (q_cmd.op)
                  OP_CLEAR: begin
                     id_count_in = '0;
                     state_in    = S_RESP;
                  end
                  OP_ADD: begin
                     if (q_cmd.status != ST_OK) begin
                        pend_in.status   = q_cmd.status;
                        pend_in.id_count = 4'(id_count_ff);
                        state_in         = S_RESP;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  OP_FRAME: state_in = S_SEARCH;
                  default:  state_in = S_IDLE;
               endcase
            end
         end

         S_SEARCH: begin
            if (miss) begin
               state_in = S_RESP;
               if (cmd_ff.op == OP_FRAME) begin
                  pend_in.kind = KIND_NOMATCH;
               end else if (id_count_ff >= CNT_W'(MAX_IDS)) begin
                  pend_in.status   = ST_ID_FULL;
                  pend_in.id_count = 4'(id_count_ff);
               end else begin
                  id_we            = 1'b1;
                  mc_we            = 1'b1;
                  mc_wdata         = MC_W'(1);
                  map_we           = 1'b1;
                  id_count_in      = id_count_ff + 1'b1;
                  pend_in.id_count = 4'(id_count_ff + 1'b1);
               end
            end else if (hit) begin
               if (cmd_ff.op == OP_FRAME) begin
                  if (mc_cur == '0) begin
                     pend_in.kind = KIND_NOMATCH;
                     state_in     = S_RESP;
                  end else begin
                     n_in     = mc_cur;
                     j_in     = '0;
                     state_in = S_READ;
                  end
               end else begin
                  state_in         = S_RESP;
                  pend_in.id_count = 4'(id_count_ff);
                  if (mc_cur >= MC_W'(MAX_MAPS)) begin
                     pend_in.status = ST_LIST_FULL;
                  end else begin
                     map_we   = 1'b1;
                     mc_we    = 1'b1;
                     mc_wdata = mc_cur + 1'b1;
                  end
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_READ: state_in = S_MUL;

         S_MUL: state_in = S_EMIT;

         S_EMIT: begin
            if (out_free) begin
               rsp_load                  = 1'b1;
               rsp_load_data             = '0;
               rsp_load_data.kind        = KIND_WRITE;
               rsp_load_data.write_index = param_ff;
               rsp_load_data.write_value = 32'(prod_ff >>> FRAC_BITS);
               rsp_load_data.last        = ((j_ff + 1'b1) == n_ff);
               if ((j_ff + 1'b1) == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         id_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         id_count_ff <= id_count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      j_ff     <= j_in;
      n_ff     <= n_in;
      pend_ff  <= pend_in;
      prod_ff  <= prod_in;
      param_ff <= map_rd_ff.param;
      if (rsp_load) begin
         rsp_data_ff <= rsp_load_data;
      end
      if (id_we) begin
         id_store[ix] <= cmd_ff.can_id;
      end
      if (mc_we) begin
         map_count[ix] <= mc_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### sim/cansm_checker.sv
// Scoreboard for the CAN signal unpack mapper: watches both channels, keeps its
// own copy of the identifier and mapping tables, predicts and compares responses.
// Depends on cansm_pkg.
`default_nettype none

module cansm_checker import cansm_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           mismatch_count,
   output int           expected_left
);

   localparam int REPORT_MAX = 10;

   int          id_total;
   logic [10:0] id_tab [MAX_IDS];
   int          map_total [MAX_IDS];
   map_type     map_tab [MAX_IDS][MAX_MAPS];
   rsp_type     expected_q [$];
   rsp_type     oldest;
   int          errors;

   function automatic logic signed [31:0] scaled_value(input logic [63:0] data,
                                                       input map_type m);
      logic [31:0]    word;
      logic [31:0]    mask;
      logic [31:0]    field;
      longint signed  fv;
      longint signed  gv;
      longint signed  prod;
      word  = (m.offset > 6'd31) ? data[63:32] : data[31:0];
      mask  = (m.length >= MAX_LENGTH) ? 32'hffff_ffff : ((32'd1 << m.length) - 32'd1);
      field = (word >> m.offset[4:0]) & mask;
      fv    = longint'($signed(field));
      gv    = longint'($signed(m.gain));
      prod  = fv * gv;
      prod  = prod >>> FRAC_BITS;
      return prod[31:0];
   endfunction

   function automatic rsp_type status_result(input logic [1:0] kind, input logic [2:0] st,
                                             input int count);
      rsp_type res;
      res          = '0;
      res.kind     = kind;
      res.status   = st;
      res.id_count = count[3:0];
      res.last     = 1'b1;
      return res;
   endfunction

   function automatic string rsp_text(input rsp_type x);
      return $sformatf("kind=%0d status=%0d count=%0d index=%0d value=%0d last=%0d",
                       x.kind, x.status, x.id_count, x.write_index, x.write_value, x.last);
   endfunction

   task automatic predict_request(input req_type r);
      int         slot;
      int         i;
      logic [2:0] st;
      rsp_type    res;
      map_type    m;
      slot = -1;
      for (i = 0; i < id_total; i++)
         if (slot < 0 && id_tab[i] == r.can_id) slot = i;
      case (r.func)
         FUNC_ADD: begin
            if (r.id_too_big) begin
               st = ST_BAD_ID;
            end else if (r.offset_too_big) begin
               st = ST_BAD_OFFSET;
            end else if (r.length_too_big || r.bit_length > MAX_LENGTH) begin
               st = ST_BAD_LENGTH;
            end else if (slot < 0 && id_total >= MAX_IDS) begin
               st = ST_ID_FULL;
            end else begin
               if (slot < 0) begin
                  slot            = id_total;
                  id_tab[slot]    = r.can_id;
                  map_total[slot] = 0;
                  id_total++;
               end
               if (map_total[slot] >= MAX_MAPS) begin
                  st = ST_LIST_FULL;
               end else begin
                  m.param  = r.param_index;
                  m.gain   = r.gain;
                  m.offset = r.bit_offset;
                  m.length = r.bit_length;
                  map_tab[slot][map_total[slot]] = m;
                  map_total[slot]++;
                  st = ST_OK;
               end
            end
            expected_q.push_back(status_result(KIND_STATUS, st, id_total));
         end
         FUNC_FRAME: begin
            if (slot < 0 || map_total[slot] == 0) begin
               expected_q.push_back(status_result(KIND_NOMATCH, ST_OK, 0));
            end else begin
               for (i = 0; i < map_total[slot]; i++) begin
                  res             = '0;
                  res.kind        = KIND_WRITE;
                  res.write_index = map_tab[slot][i].param;
                  res.write_value = scaled_value(r.frame_data, map_tab[slot][i]);
                  res.last        = (i == map_total[slot] - 1);
                  expected_q.push_back(res);
               end
            end
         end
         FUNC_CLEAR: begin
            id_total = 0;
            for (i = 0; i < MAX_IDS; i++) map_total[i] = 0;
            expected_q.push_back(status_result(KIND_STATUS, ST_OK, 0));
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         id_total  = 0;
         map_total = '{default: 0};
         expected_q.delete();
         errors    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("unexpected response: %s", rsp_text(rsp_data));
            end else begin
               oldest = expected_q.pop_front();
               if (oldest.kind != rsp_data.kind || oldest.status != rsp_data.status ||
                   oldest.id_count != rsp_data.id_count ||
                   oldest.write_index != rsp_data.write_index ||
                   oldest.write_value != rsp_data.write_value ||
                   oldest.last != rsp_data.last) begin
                  errors++;
                  if (errors <= REPORT_MAX)
                     $display("response mismatch: expected %s, got %s",
                              rsp_text(oldest), rsp_text(rsp_data));
               end
            end
         end
         if (req_valid && req_ready) predict_request(req_data);
      end
      mismatch_count <= errors;
      expected_left  <= expected_q.size();
   end

endmodule

`default_nettype wire

### sim/testbench.sv
// Top of the CAN signal unpack mapper testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on cansm_pkg, cansm_checker
// and the can_signal_unpack_mapper RTL.
`default_nettype none

module testbench;
   import cansm_pkg::*;

   localparam int         CYCLE_LIMIT = 100000;
   localparam int         ROUNDS      = 4;
   localparam int         ROUND_ITEMS = 32;
   localparam int         HOLD_CYCLES = 400;
   localparam int         IDLE_PCT    = 7;
   localparam int         TAIL_CYCLES = 64;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      mismatch_count;
   int      expected_left;
   logic    hold_off  = 1'b0;
   logic    hold_done = 1'b0;
   logic    calm      = 1'b0;
   int      hold_left = 0;
   int      cycle_count = 0;

   can_signal_unpack_mapper uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   cansm_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .expected_left  (expected_left)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_off && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   function automatic req_type noise_req();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type add_req(input logic [10:0] id, input logic [7:0] param,
                                       input logic [5:0] off, input logic [5:0] len,
                                       input logic signed [7:0] gain);
      req_type r;
      r                = noise_req();
      r.func           = FUNC_ADD;
      r.can_id         = id;
      r.param_index    = param;
      r.bit_offset     = off;
      r.bit_length     = len;
      r.gain           = gain;
      r.offset_too_big = 1'b0;
      r.length_too_big = 1'b0;
      r.id_too_big     = 1'b0;
      return r;
   endfunction

   function automatic req_type frame_req(input logic [10:0] id, input logic [63:0] data);
      req_type r;
      r            = noise_req();
      r.func       = FUNC_FRAME;
      r.can_id     = id;
      r.frame_data = data;
      return r;
   endfunction

   function automatic req_type clear_req();
      req_type r;
      r      = noise_req();
      r.func = FUNC_CLEAR;
      return r;
   endfunction

   function automatic req_type random_add(input logic [10:0] id);
      logic [5:0] off;
      logic [5:0] len;
      case ($urandom_range(5))
         0:       off = 6'd0;
         1:       off = 6'd31;
         2:       off = 6'd32;
         3:       off = 6'd63;
         default: off = 6'($urandom_range(63));
      endcase
      case ($urandom_range(5))
         0:       len = 6'd0;
         1:       len = 6'd32;
         2:       len = 6'd1;
         default: len = 6'($urandom_range(32));
      endcase
      return add_req(id, 8'($urandom_range(255)), off, len, 8'($urandom_range(255)));
   endfunction

   function automatic logic [63:0] random_payload();
      case ($urandom_range(9))
         0:       return '1;
         1:       return '0;
         2:       return 64'h8000_0000_8000_0000;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic offer(input req_type r);
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   initial begin
      int          round;
      int          count;
      int          pick;
      int          pool_n;
      int          i;
      req_type     r;
      logic [10:0] pool [13];

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      offer(clear_req());
      offer(frame_req(11'h7ff, '1));
      offer(add_req(11'h000, 8'd0, 6'd0, 6'd0, 8'sd0));
      offer(add_req(11'h7ff, 8'd255, 6'd63, 6'd32, -8'sd128));
      offer(add_req(11'h7ff, 8'd1, 6'd32, 6'd32, 8'sd127));
      offer(add_req(11'h7ff, 8'd2, 6'd31, 6'd32, -8'sd1));
      offer(add_req(11'h7ff, 8'd3, 6'd0, 6'd32, 8'sd1));
      offer(add_req(11'h7ff, 8'd4, 6'd5, 6'd17, 8'sd32));
      offer(add_req(11'h7ff, 8'd5, 6'd63, 6'd1, -8'sd128));
      offer(add_req(11'h7ff, 8'd6, 6'd0, 6'd1, 8'sd127));
      offer(add_req(11'h7ff, 8'd7, 6'd40, 6'd24, -8'sd77));
      offer(add_req(11'h7ff, 8'd8, 6'd8, 6'd8, 8'sd3));
      r = add_req(11'h7ff, 8'd9, 6'd63, 6'd63, 8'sd5);
      {r.id_too_big, r.offset_too_big, r.length_too_big} = 3'b111;
      offer(r);
      r = add_req(11'h123, 8'd9, 6'd1, 6'd2, 8'sd5);
      {r.offset_too_big, r.length_too_big} = 2'b11;
      offer(r);
      r = add_req(11'h123, 8'd9, 6'd1, 6'd2, 8'sd5);
      r.length_too_big = 1'b1;
      offer(r);
      offer(add_req(11'h123, 8'd9, 6'd1, 6'd33, 8'sd5));
      offer(add_req(11'h123, 8'd9, 6'd1, 6'd63, 8'sd5));
      offer(frame_req(11'h7ff, '1));
      offer(frame_req(11'h7ff, 64'h8000_0000_8000_0000));
      offer(frame_req(11'h7ff, '0));
      offer(frame_req(11'h000, {$urandom, $urandom}));
      offer(frame_req(11'h601, {$urandom, $urandom}));
      r = noise_req();
      r.func = FUNC_UNUSED;
      offer(r);
      offer(clear_req());
      offer(frame_req(11'h7ff, '1));
      wait_drained();

      for (round = 0; round < ROUNDS; round++) begin
         pool_n = (round == 0) ? 3 : (round == 1) ? 13 : $urandom_range(13, 2);
         for (i = 0; i < pool_n; i++) pool[i] = 11'($urandom_range(2047));
         calm <= (round == 2);
         if (round == 1) hold_off <= 1'b1;
         offer(clear_req());
         count = 1;
         while (count < ROUND_ITEMS) begin
            maybe_idle();
            pick = $urandom_range(99);
            if (pick < 45) begin
               offer(frame_req(pool[$urandom_range(pool_n - 1)], random_payload()));
            end else if (pick < 82) begin
               offer(random_add(pool[$urandom_range(pool_n - 1)]));
            end else if (pick < 90) begin
               r = random_add(pool[$urandom_range(pool_n - 1)]);
               if ($urandom_range(1))
                  {r.id_too_big, r.offset_too_big, r.length_too_big} =
                     3'($urandom_range(7, 1));
               else
                  r.bit_length = 6'($urandom_range(63, 33));
               offer(r);
            end else if (pick < 95) begin
               offer(frame_req(11'($urandom_range(2047)), random_payload()));
            end else if (pick < 97) begin
               offer(clear_req());
            end else begin
               r = noise_req();
               r.func = FUNC_UNUSED;
               offer(r);
               count--;
            end
            count++;
         end
         wait_drained();
      end

      calm <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_left == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
